// ===== rtl/multilevel_page_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Page table assertion macros
// Shared concurrent check forms for the page table RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PAGE_TABLE_TOP_DEFINES_SVH
`define MULTILEVEL_PAGE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MLPT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlpt: same-cycle check failed");

// next-cycle implication, checked outside reset
`define MLPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlpt: next-cycle check failed");

`endif

// ===== rtl/mlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Page table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mlpt_pkg;

	// default parameter values
	localparam int MAX_LEVELS_DEF     = 4;
	localparam int MAX_LEVEL_BITS_DEF = 8;
	localparam int NODE_POOL_DEF      = 64;
	localparam int FRAME_BITS_DEF     = 20;

	// fixed field widths
	localparam int VA_W        = 32;
	localparam int FRAME_NUM_W = 20;
	localparam int STATUS_W    = 2;
	localparam int LEVEL_REGS  = 4;
	localparam int DEPTH_W     = 2;
	localparam int LVL_CNT_W   = 3;
	localparam int BITS_W      = 4;
	localparam int VPN_W       = 6;
	localparam int OW_W        = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_BITS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3_BITS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VPN_BITS    = 3'd5;

	// request kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		RES_NONE = 3'd0,
		RES_MAP  = 3'd1,
		RES_HIT  = 3'd2,
		RES_MISS = 3'd3,
		RES_FULL = 3'd4
	} res_t;

	typedef struct packed {
		logic [LVL_CNT_W-1:0]             levels;
		logic [LEVEL_REGS-1:0][BITS_W-1:0] bits;
		logic [OW_W-1:0]                  ow;
	} cfg_eff_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic rd;
		logic wr_leaf;
		logic follow;
		logic alloc;
		logic mod_start;
		logic mod_follow;
		res_t res;
		logic deliver;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic kind;
		logic leaf;
		logic frame_full;
		logic rd_valid;
		logic rd_small;
		logic room;
		logic mod_done;
	} dp_stat_t;

endpackage

// ===== rtl/mlpt_datapath.sv =====
// ----------------------------------------------------------------------------
// Page table datapath
// Entry memory, walk registers, node and frame counters, child modulo unit.
// ----------------------------------------------------------------------------
module mlpt_datapath #(
	parameter int MAX_LEVEL_BITS = mlpt_pkg::MAX_LEVEL_BITS_DEF,
	parameter int NODE_POOL      = mlpt_pkg::NODE_POOL_DEF,
	parameter int FRAME_BITS     = mlpt_pkg::FRAME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlpt_pkg::cfg_eff_t              cfg,
	input  mlpt_pkg::dp_cmd_t               cmd,
	output mlpt_pkg::dp_stat_t              stat,
	input  logic                            in_kind,
	input  logic [mlpt_pkg::VA_W-1:0]       in_va,
	output logic [mlpt_pkg::STATUS_W-1:0]   res_status,
	output logic [FRAME_BITS-1:0]           res_frame,
	output logic [mlpt_pkg::VA_W-1:0]       res_va
);

	localparam int SPAN   = 1 << MAX_LEVEL_BITS;
	localparam int DEPTH  = NODE_POOL * SPAN;
	localparam int NODE_W = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
	localparam int ADDR_W = NODE_W + MAX_LEVEL_BITS;
	localparam int NF_W   = $clog2(NODE_POOL + 1);
	localparam int CW     = NF_W + 3;
	localparam int PW     = (FRAME_BITS > NODE_W) ? FRAME_BITS : NODE_W;
	localparam int ENT_W  = PW + 1;

	// reciprocal of the pool size, exact for every payload value
	localparam int     MOD_SHIFT = PW + $clog2(NODE_POOL);
	localparam longint MOD_MAGIC = (longint'(1) << MOD_SHIFT) / NODE_POOL + 1;
	localparam int     MAGIC_W   = PW + 2;
	localparam int     PROD_W    = PW + MAGIC_W;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rdata_q;

	logic                           kind_q;
	logic [mlpt_pkg::VA_W-1:0]      va_q;
	logic [mlpt_pkg::VA_W-1:0]      cur_q;
	logic [mlpt_pkg::DEPTH_W-1:0]   depth_q;
	logic [NODE_W-1:0]              node_q;
	logic [NF_W-1:0]                nf_q;
	logic [FRAME_BITS:0]            next_frame_q;
	logic [ADDR_W-1:0]              clr_q;
	logic [mlpt_pkg::STATUS_W-1:0]  status_q;
	logic [FRAME_BITS-1:0]          frame_q;

	logic [PW-1:0]     dvd_q;
	logic [PROD_W-1:0] prod_q;
	logic [NODE_W-1:0] rem_q;
	logic              mod_pend_q;

	logic [mlpt_pkg::BITS_W-1:0]    b_eff;
	logic [MAX_LEVEL_BITS-1:0]      idx_top;
	logic [MAX_LEVEL_BITS-1:0]      idx;
	logic [ADDR_W-1:0]              slot;
	logic [ADDR_W-1:0]              addr;
	logic                           we;
	logic [ENT_W-1:0]               wdata;
	logic [PW-1:0]                  payload;
	logic [mlpt_pkg::LVL_CNT_W-1:0] depth_ext;
	logic [mlpt_pkg::LVL_CNT_W-1:0] needed;
	logic [NF_W-1:0]                nodes_left;
	logic [PW-1:0]                  quo;
	logic [PW:0]                    rem_full;
	logic                           mod_done;

	// slot of the current level
	always_comb begin
		b_eff     = cfg.bits[depth_q];
		idx_top   = cur_q[mlpt_pkg::VA_W-1 -: MAX_LEVEL_BITS];
		idx       = idx_top >> (mlpt_pkg::BITS_W'(MAX_LEVEL_BITS) - b_eff);
		slot      = {node_q, idx};
		payload   = rdata_q[PW-1:0];
		depth_ext = {1'b0, depth_q};
		needed    = cfg.levels - 3'd1 - depth_ext;
		nodes_left = NF_W'(NODE_POOL) - nf_q;
	end

	// memory port select
	always_comb begin
		we    = cmd.clear_wr | cmd.alloc | cmd.wr_leaf;
		addr  = cmd.clear_wr ? clr_q : slot;
		if (cmd.clear_wr) begin
			wdata = '0;
		end else if (cmd.alloc) begin
			wdata = {1'b1, PW'(nf_q)};
		end else begin
			wdata = {1'b1, PW'(next_frame_q[FRAME_BITS-1:0])};
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	// quotient from the registered product, then remainder
	always_comb begin
		quo      = PW'(prod_q >> MOD_SHIFT);
		rem_full = (PW + 1)'(dvd_q) - (PW + 1)'(quo) * (PW + 1)'(NODE_POOL);
		mod_done = !mod_pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_pend_q <= 1'b0;
		end else begin
			mod_pend_q <= cmd.mod_start;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			dvd_q  <= payload;
			prod_q <= PROD_W'(payload) * PROD_W'(MOD_MAGIC);
		end
		if (mod_pend_q) begin
			rem_q <= NODE_W'(rem_full);
		end
	end

	// clear sweep, node and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			nf_q         <= NF_W'(1);
			next_frame_q <= '0;
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.alloc) begin
				nf_q <= nf_q + NF_W'(1);
			end
			if (cmd.wr_leaf) begin
				next_frame_q <= next_frame_q + (FRAME_BITS + 1)'(1);
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			va_q    <= in_va;
			cur_q   <= in_va;
			depth_q <= '0;
			node_q  <= '0;
		end else if (cmd.follow || cmd.alloc || cmd.mod_follow) begin
			cur_q   <= cur_q << b_eff;
			depth_q <= depth_q + mlpt_pkg::DEPTH_W'(1);
			if (cmd.follow) begin
				node_q <= NODE_W'(payload);
			end else if (cmd.alloc) begin
				node_q <= NODE_W'(nf_q);
			end else begin
				node_q <= rem_q;
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		case (cmd.res)
			mlpt_pkg::RES_MAP: begin
				status_q <= mlpt_pkg::STATUS_OK;
				frame_q  <= next_frame_q[FRAME_BITS-1:0];
			end
			mlpt_pkg::RES_HIT: begin
				status_q <= mlpt_pkg::STATUS_OK;
				frame_q  <= payload[FRAME_BITS-1:0];
			end
			mlpt_pkg::RES_MISS: begin
				status_q <= mlpt_pkg::STATUS_MISS;
				frame_q  <= '0;
			end
			mlpt_pkg::RES_FULL: begin
				status_q <= mlpt_pkg::STATUS_FULL;
				frame_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
		stat.kind       = kind_q;
		stat.leaf       = ((depth_ext + 3'd1) == cfg.levels);
		stat.frame_full = next_frame_q[FRAME_BITS];
		stat.rd_valid   = rdata_q[PW];
		stat.rd_small   = ((PW + 1)'(payload) < (PW + 1)'(NODE_POOL));
		stat.room       = (CW'(needed) <= CW'(nodes_left));
		stat.mod_done   = mod_done;
	end

	assign res_status = status_q;
	assign res_frame  = frame_q;
	assign res_va     = va_q;

endmodule

// ===== rtl/mlpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page table controller
// Sequences the clear sweep and the level-by-level walk of each request.
// ----------------------------------------------------------------------------
`include "multilevel_page_table_top_defines.svh"

module mlpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  mlpt_pkg::dp_stat_t stat,
	input  logic               out_free,
	input  logic               in_valid,
	output logic               in_ready,
	output mlpt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ISSUE = 6'b000100,
		ST_WAIT  = 6'b001000,
		ST_MOD   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.res  = mlpt_pkg::RES_NONE;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (stat.kind == mlpt_pkg::KIND_INSERT && stat.frame_full) begin
					cmd.res = mlpt_pkg::RES_FULL;
					state_d = ST_DONE;
				end else if (stat.kind == mlpt_pkg::KIND_INSERT && stat.leaf) begin
					cmd.wr_leaf = 1'b1;
					cmd.res     = mlpt_pkg::RES_MAP;
					state_d     = ST_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.leaf) begin
					cmd.res = stat.rd_valid ? mlpt_pkg::RES_HIT : mlpt_pkg::RES_MISS;
					state_d = ST_DONE;
				end else if (stat.rd_valid) begin
					if (stat.rd_small) begin
						cmd.follow = 1'b1;
						state_d    = ST_ISSUE;
					end else begin
						cmd.mod_start = 1'b1;
						state_d       = ST_MOD;
					end
				end else if (stat.kind == mlpt_pkg::KIND_INSERT && stat.room) begin
					cmd.alloc = 1'b1;
					state_d   = ST_ISSUE;
				end else begin
					cmd.res = (stat.kind == mlpt_pkg::KIND_INSERT) ?
					          mlpt_pkg::RES_FULL : mlpt_pkg::RES_MISS;
					state_d = ST_DONE;
				end
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					cmd.mod_follow = 1'b1;
					state_d        = ST_ISSUE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`MLPT_ASSERT_IMPLIES(a_deliver_free, cmd.deliver, out_free)
	`MLPT_ASSERT_IMPLIES(a_alloc_room, cmd.alloc, stat.room && !stat.leaf)
	`MLPT_ASSERT_IMPLIES(a_leaf_write, cmd.wr_leaf, stat.leaf && !stat.frame_full)
	`MLPT_ASSERT_NEXT(a_load_walk, cmd.load, state_q == ST_ISSUE)

endmodule

// ===== rtl/multilevel_page_table_top.sv =====
// ----------------------------------------------------------------------------
// Multilevel page table
// Radix page table over 32-bit virtual addresses with insert and lookup.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser is the kind (insert or lookup),
// s_tdata the virtual address. One result per request leaves on the m_
// stream: m_tuser carries status, m_tdata the frame and physical address.
// Registers are to be written through the cfg_ channel only while no
// request is open; the block itself does not enforce this. After reset the
// entry memory is swept clear, one entry a cycle, over all NODE_POOL *
// 2^MAX_LEVEL_BITS entries (16384 by default); s_tready stays low until
// then, configuration writes are taken throughout. A request walks the
// levels one at a time: an interior level is a memory read, then a decision;
// an insert writes the leaf directly, a lookup reads it. The request is
// loaded first and handed off last. A child link that points past the node
// pool is reduced modulo the pool size in the reciprocal modulo unit. The
// single memory port sets the rate: one request is in the walk at a time.
// A result sits in the output register until taken; the next request is
// accepted meanwhile and its result waits in the walk until the register
// frees.
// ----------------------------------------------------------------------------
module multilevel_page_table_top #(
	parameter int MAX_LEVELS     = mlpt_pkg::MAX_LEVELS_DEF,
	parameter int MAX_LEVEL_BITS = mlpt_pkg::MAX_LEVEL_BITS_DEF,
	parameter int NODE_POOL      = mlpt_pkg::NODE_POOL_DEF,
	parameter int FRAME_BITS     = mlpt_pkg::FRAME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // virt_addr
	input  logic                              s_tuser,   // kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,   // frame_num, phys_addr, zero pad
	output logic [1:0]                        m_tuser,   // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mlpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mlpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LEVEL_LIM = (MAX_LEVELS < mlpt_pkg::LEVEL_REGS) ?
	                           MAX_LEVELS : mlpt_pkg::LEVEL_REGS;

	logic [mlpt_pkg::LVL_CNT_W-1:0]                     level_count_q;
	logic [mlpt_pkg::LEVEL_REGS-1:0][mlpt_pkg::BITS_W-1:0] level_bits_q;
	logic [mlpt_pkg::VPN_W-1:0]                         vpn_bits_q;

	mlpt_pkg::cfg_eff_t cfg_eff;
	mlpt_pkg::dp_cmd_t  cmd;
	mlpt_pkg::dp_stat_t stat;

	logic [mlpt_pkg::STATUS_W-1:0] res_status;
	logic [FRAME_BITS-1:0]         res_frame;
	logic [mlpt_pkg::VA_W-1:0]     res_va;
	logic [mlpt_pkg::VA_W-1:0]     phys;
	logic [mlpt_pkg::VA_W-1:0]     off_mask;
	logic                          out_free;

	logic                             m_valid_q;
	logic [mlpt_pkg::STATUS_W-1:0]    m_status_q;
	logic [mlpt_pkg::FRAME_NUM_W-1:0] m_frame_q;
	logic [mlpt_pkg::VA_W-1:0]        m_phys_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= 3'd1;
			level_bits_q  <= {mlpt_pkg::LEVEL_REGS{4'd8}};
			vpn_bits_q    <= 6'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				mlpt_pkg::CFG_LEVEL_COUNT: level_count_q   <= cfg_data[2:0];
				mlpt_pkg::CFG_LEVEL0_BITS: level_bits_q[0] <= cfg_data[3:0];
				mlpt_pkg::CFG_LEVEL1_BITS: level_bits_q[1] <= cfg_data[3:0];
				mlpt_pkg::CFG_LEVEL2_BITS: level_bits_q[2] <= cfg_data[3:0];
				mlpt_pkg::CFG_LEVEL3_BITS: level_bits_q[3] <= cfg_data[3:0];
				mlpt_pkg::CFG_VPN_BITS:    vpn_bits_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// clamp register values into the usable range
	always_comb begin
		if (level_count_q == 3'd0) begin
			cfg_eff.levels = 3'd1;
		end else if (level_count_q > 3'(LEVEL_LIM)) begin
			cfg_eff.levels = 3'(LEVEL_LIM);
		end else begin
			cfg_eff.levels = level_count_q;
		end
		for (int i = 0; i < mlpt_pkg::LEVEL_REGS; i++) begin
			if (level_bits_q[i] == 4'd0) begin
				cfg_eff.bits[i] = 4'd1;
			end else if (level_bits_q[i] > 4'(MAX_LEVEL_BITS)) begin
				cfg_eff.bits[i] = 4'(MAX_LEVEL_BITS);
			end else begin
				cfg_eff.bits[i] = level_bits_q[i];
			end
		end
		if (vpn_bits_q == 6'd0) begin
			cfg_eff.ow = 5'd31;
		end else if (vpn_bits_q > 6'd32) begin
			cfg_eff.ow = 5'd0;
		end else begin
			cfg_eff.ow = 5'(6'd32 - vpn_bits_q);
		end
	end

	mlpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.out_free (out_free),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	mlpt_datapath #(
		.MAX_LEVEL_BITS (MAX_LEVEL_BITS),
		.NODE_POOL      (NODE_POOL),
		.FRAME_BITS     (FRAME_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_eff),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_tuser),
		.in_va      (s_tdata),
		.res_status (res_status),
		.res_frame  (res_frame),
		.res_va     (res_va)
	);

	// physical address from frame and page offset
	always_comb begin
		off_mask = (32'd1 << cfg_eff.ow) - 32'd1;
		if (res_status == mlpt_pkg::STATUS_OK) begin
			phys = (32'(res_frame) << cfg_eff.ow) | (res_va & off_mask);
		end else begin
			phys = '0;
		end
	end

	// output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			m_status_q <= res_status;
			m_frame_q  <= mlpt_pkg::FRAME_NUM_W'(res_frame);
			m_phys_q   <= phys;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {4'd0, m_phys_q, m_frame_q};

endmodule

// ===== sim/multilevel_page_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// Multilevel page table testbench
// Drives insert and lookup requests under many table layouts, predicts each
// translation with a local copy of the radix table, and checks every result
// field by field with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module multilevel_page_table_top_tb;
	import mlpt_pkg::*;

	localparam int SPAN_BITS  = 8;
	localparam int POOL_NODES = 64;
	localparam int STORE_SIZE = POOL_NODES << SPAN_BITS;
	localparam longint FRAME_CAP = 64'd1 << 20;

	typedef struct {
		logic [STATUS_W-1:0]    status;
		logic [FRAME_NUM_W-1:0] frame;
		logic [31:0]            phys;
	} xlat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;   // frame_num, phys_addr, zero pad
	logic [1:0]           m_tuser;   // status
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the table and its registers
	bit          tbl_valid [STORE_SIZE];
	int unsigned tbl_payload [STORE_SIZE];
	int          free_node;
	longint      frame_ctr;
	int unsigned reg_file [6];

	xlat_t       pending_xlat [$];
	logic [31:0] mapped_va [$];
	int          mismatches;
	int          checked;
	int          n_full;
	int          n_hit;
	int          n_miss;
	bit          no_gaps;
	int          stall_hold;

	multilevel_page_table_top dut (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// effective layout after clamping the raw registers
	function automatic int eff_levels();
		int n;
		n = reg_file[CFG_LEVEL_COUNT];
		if (n < 1) n = 1;
		if (n > 4) n = 4;
		return n;
	endfunction

	function automatic int eff_bits(input int d);
		int b;
		b = reg_file[CFG_LEVEL0_BITS + d];
		if (b < 1) b = 1;
		if (b > SPAN_BITS) b = SPAN_BITS;
		return b;
	endfunction

	function automatic int offset_width();
		int v;
		v = reg_file[CFG_VPN_BITS];
		if (v < 1) v = 1;
		if (v > 32) v = 32;
		return 32 - v;
	endfunction

	// follow the path of va; on a missing link report its depth
	function automatic bit table_walk(input logic [31:0] va, input bit alloc,
			output int leaf, output int miss);
		int levels, cum, node, idx, slot, b;
		logic [63:0] wide;
		levels = eff_levels();
		cum = 0;
		node = 0;
		wide = {va, 32'd0};
		leaf = 0;
		miss = 0;
		for (int d = 0; d < levels; d++) begin
			b = eff_bits(d);
			cum += b;
			idx = int'((wide >> (64 - cum)) & ((64'd1 << b) - 1));
			slot = (node * (1 << SPAN_BITS) + idx) % STORE_SIZE;
			if (d + 1 == levels) begin
				leaf = slot;
				return 1'b1;
			end
			if (tbl_valid[slot]) begin
				node = tbl_payload[slot] % POOL_NODES;
			end else if (alloc && free_node < POOL_NODES) begin
				node = free_node;
				free_node++;
				tbl_valid[slot] = 1'b1;
				tbl_payload[slot] = node;
			end else begin
				miss = d;
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [31:0] phys_of(input longint frame, input logic [31:0] va);
		int ow;
		logic [63:0] mask;
		ow = offset_width();
		mask = (64'd1 << ow) - 1;
		return 32'(((64'(frame) << ow) | (64'(va) & mask)));
	endfunction

	// predict one translation and update the shadow table
	function automatic xlat_t translate(input logic kind, input logic [31:0] va);
		xlat_t r;
		int leaf, miss, needed;
		bit ok;
		r.status = STATUS_MISS;
		r.frame = '0;
		r.phys = '0;
		if (kind == KIND_INSERT) begin
			ok = frame_ctr < FRAME_CAP;
			if (ok && !table_walk(va, 1'b0, leaf, miss)) begin
				needed = eff_levels() - 1 - miss;
				if (needed > POOL_NODES - free_node) ok = 1'b0;
			end
			if (ok && table_walk(va, 1'b1, leaf, miss)) begin
				tbl_valid[leaf] = 1'b1;
				tbl_payload[leaf] = int'(frame_ctr % FRAME_CAP);
				r.status = STATUS_OK;
				r.frame = FRAME_NUM_W'(frame_ctr);
				r.phys = phys_of(frame_ctr % FRAME_CAP, va);
				frame_ctr++;
			end else begin
				r.status = STATUS_FULL;
			end
		end else if (table_walk(va, 1'b0, leaf, miss) && tbl_valid[leaf]) begin
			r.status = STATUS_OK;
			r.frame = FRAME_NUM_W'(tbl_payload[leaf]);
			r.phys = phys_of(tbl_payload[leaf] % FRAME_CAP, va);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one request; returns just after the accepting edge plus any gap
	task automatic send_req(input logic kind, input logic [31:0] va);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= va;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_xlat.push_back(translate(kind, va));
		if (kind == KIND_INSERT && mapped_va.size() < 256) mapped_va.push_back(va);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_LEVEL_COUNT: reg_file[idx] = val & 6'h07;
			CFG_VPN_BITS: reg_file[idx] = val;
			default: reg_file[idx] = val & 6'h0F;
		endcase
	endtask

	// hold the sender until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_xlat.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_layout(input int lc, input int b0, input int b1, input int b2,
			input int b3, input int vpn);
		drain();
		write_reg(CFG_LEVEL_COUNT, lc);
		write_reg(CFG_LEVEL0_BITS, b0);
		write_reg(CFG_LEVEL1_BITS, b1);
		write_reg(CFG_LEVEL2_BITS, b2);
		write_reg(CFG_LEVEL3_BITS, b3);
		write_reg(CFG_VPN_BITS, vpn);
		cfg_valid <= 1'b0;
	endtask

	// reset layout: single level, insert, hit, miss, overwrite
	task automatic test_directed();
		send_req(KIND_LOOKUP, 32'h0000_0000);
		send_req(KIND_INSERT, 32'h0000_0000);
		send_req(KIND_INSERT, 32'hFFFF_FFFF);
		send_req(KIND_LOOKUP, 32'h00AB_CDEF);
		send_req(KIND_LOOKUP, 32'hFF00_0001);
		send_req(KIND_LOOKUP, 32'h1234_5678);
		send_req(KIND_INSERT, 32'h0000_1234);
		send_req(KIND_LOOKUP, 32'h0000_0000);
		// four full levels, whole address as page number
		set_layout(4, 8, 8, 8, 8, 32);
		send_req(KIND_INSERT, 32'hDEAD_BEEF);
		send_req(KIND_LOOKUP, 32'hDEAD_BEEF);
		send_req(KIND_LOOKUP, 32'hDEAD_BEEE);
		send_req(KIND_INSERT, 32'h8000_0000);
		send_req(KIND_LOOKUP, 32'h8000_0000);
		// out-of-range registers clamp
		set_layout(0, 0, 15, 9, 0, 0);
		send_req(KIND_INSERT, 32'h7FFF_FFFF);
		send_req(KIND_LOOKUP, 32'h7FFF_0000);
		set_layout(7, 15, 0, 12, 15, 63);
		send_req(KIND_INSERT, 32'h0F0F_0F0F);
		send_req(KIND_LOOKUP, 32'h0F0F_0F0F);
		set_layout(5, 8, 8, 8, 8, 40);
		send_req(KIND_LOOKUP, 32'hDEAD_BEEF);
		send_req(KIND_INSERT, 32'h0000_0001);
		send_req(KIND_LOOKUP, 32'h0000_0001);
	endtask

	// deep tables until the node pool runs dry
	task automatic test_pool_exhaust();
		set_layout(4, 8, 8, 8, 8, 32);
		for (int i = 0; i < 40; i++) send_req(KIND_INSERT, $urandom());
		for (int i = 0; i < 8; i++) send_req(KIND_LOOKUP, mapped_va[$urandom_range(0,
			mapped_va.size() - 1)]);
	endtask

	function automatic logic [31:0] pick_addr();
		logic [31:0] va;
		int r;
		r = $urandom_range(0, 9);
		if (mapped_va.size() == 0 || r < 3) return $urandom();
		va = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
		if (r < 6) va ^= 32'($urandom_range(0, 255));
		return va;
	endfunction

	// random layouts, live entries carried over between them
	task automatic test_random_layouts();
		int lc;
		for (int ph = 0; ph < 8; ph++) begin
			lc = (ph == 0) ? 1 : (ph == 1) ? 4 : $urandom_range(0, 7);
			if (ph == 2) set_layout(lc, 1, 1, 1, 1, 1);
			else if (ph == 3) set_layout(4, 8, 8, 8, 8, 32);
			else set_layout(lc, $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 63));
			no_gaps = (ph == 5);
			for (int i = 0; i < 80; i++)
				send_req($urandom_range(0, 2) == 0 ? KIND_INSERT : KIND_LOOKUP, pick_addr());
			no_gaps = 1'b0;
		end
	endtask

	// receiver stalls: runs of ready, mostly short stalls, a few long
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if ($urandom_range(0, 2) != 0) begin
			m_tready <= 1'b1;
			stall_hold = $urandom_range(0, 20);
		end else begin
			m_tready <= 1'b0;
			stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		xlat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			checked++;
			if (pending_xlat.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: status %0d frame %h",
					m_tuser, m_tdata[19:0]);
			end else begin
				want = pending_xlat.pop_front();
				case (want.status)
					STATUS_FULL: n_full++;
					STATUS_MISS: n_miss++;
					default: n_hit++;
				endcase
				if (m_tuser !== want.status || m_tdata[19:0] !== want.frame ||
						m_tdata[51:20] !== want.phys) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d fr %h pa %h, got st %0d fr %h pa %h",
							want.status, want.frame, want.phys,
							m_tuser, m_tdata[19:0], m_tdata[51:20]);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_INSERT;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LEVEL_COUNT;
		cfg_data <= '0;
		stall_hold = 0;
		mismatches = 0;
		checked = 0;
		n_full = 0;
		n_hit = 0;
		n_miss = 0;
		no_gaps = 1'b0;
		free_node = 1;
		frame_ctr = 0;
		reg_file = '{1, 8, 8, 8, 8, 8};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_exhaust();
		test_random_layouts();
		drain();
		mismatches += pending_xlat.size();
		$display("Checked %0d translations over several layouts: %0d ok, %0d miss, %0d full.",
			checked, n_hit, n_miss, n_full);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#1_500_000;
		$display("Verification failed");
		$finish;
	end

endmodule
